/* rtl/acm_pkg.sv */
// Shared types and constants for the ADC scan limit monitor.
package acm_pkg;

    localparam int DATA_W = 24;
    localparam int DIV_W  = 8;
    localparam int CH_W   = 2;
    localparam int CODE_W = 3;
    localparam int IDX_W  = 3;
    localparam int CNT_W  = $clog2(DATA_W);

    localparam int DEF_NUM_CHANNELS     = 3;
    localparam int DEF_SAMPLE_BITS      = 24;
    localparam int DEF_FALL_CHANNEL     = 0;
    localparam int DEF_PRESSURE_CHANNEL = 1;

    localparam logic [DATA_W-1:0] LIMIT_MIN_RST = '0;
    localparam logic [DATA_W-1:0] LIMIT_MAX_RST = '1;
    localparam logic [DIV_W-1:0]  DIVISOR_RST   = DIV_W'(2);

    typedef enum logic [CODE_W-1:0] {
        EV_NONE      = 3'd0,
        EV_NOT_READY = 3'd1,
        EV_OVERLOAD  = 3'd2,
        EV_MAX       = 3'd3,
        EV_MIN       = 3'd4,
        EV_FALL      = 3'd5,
        EV_PRESSURE  = 3'd6
    } t_event;

    typedef enum logic [IDX_W-1:0] {
        REG_MIN_CH0   = 3'd0,
        REG_MAX_CH0   = 3'd1,
        REG_MIN_CH1   = 3'd2,
        REG_MAX_CH1   = 3'd3,
        REG_MIN_CH2   = 3'd4,
        REG_MAX_CH2   = 3'd5,
        REG_DIVISOR   = 3'd6,
        REG_SETPOINT  = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic lt;
        logic gt;
    } t_cmp;

endpackage

/* rtl/acm_div_serial.sv */
// Bit-serial restoring divider, one quotient bit per step, MSB first.
module acm_div_serial (
    input  logic                        i_clk,
    input  logic                        i_start,
    input  logic                        i_step,
    input  logic [acm_pkg::DATA_W-1:0]  i_dividend,
    input  logic [acm_pkg::DIV_W-1:0]   i_divisor,
    output logic                        o_qbit
);
    import acm_pkg::*;

    logic [DATA_W-1:0] r_dvd;
    logic [DIV_W-1:0]  r_rem;
    logic [DIV_W-1:0]  r_dsr;
    logic [DIV_W:0]    w_trial;
    logic [DIV_W:0]    w_diff;
    logic              w_qbit;
    logic [DIV_W-1:0]  n_rem;

    always_comb begin
        w_trial = {r_rem, r_dvd[DATA_W-1]};
        w_diff  = w_trial - {1'b0, r_dsr};
        w_qbit  = (w_trial >= {1'b0, r_dsr});
        n_rem   = w_qbit ? w_diff[DIV_W-1:0] : w_trial[DIV_W-1:0];
    end

    assign o_qbit = w_qbit;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_rem <= '0;
            // treat a zero divisor as one
            r_dsr <= (i_divisor == '0) ? DIV_W'(1) : i_divisor;
        end else if (i_step) begin
            r_dvd <= {r_dvd[DATA_W-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

endmodule

/* rtl/acm_cmp_serial.sv */
// Bit-serial magnitude comparator, operands presented MSB first.
module acm_cmp_serial (
    input  logic          i_clk,
    input  logic          i_start,
    input  logic          i_step,
    input  logic          i_a,
    input  logic          i_b,
    output acm_pkg::t_cmp o_cmp
);
    import acm_pkg::*;

    t_cmp r_cmp;
    t_cmp n_cmp;

    always_comb begin
        n_cmp = r_cmp;
        if (!r_cmp.lt && !r_cmp.gt) begin
            n_cmp.lt = !i_a && i_b;
            n_cmp.gt = i_a && !i_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cmp <= '0;
        end else if (i_step) begin
            r_cmp <= n_cmp;
        end
    end

    assign o_cmp = r_cmp;

endmodule

/* rtl/adc_scan_limit_monitor.sv */
// Top level of the ADC scan limit monitor.
//
// Input channel: i_valid / o_stall carry one converter event (not-ready flag,
// overload flag, sample) for the channel that the scan pointer selects.
// Output channel: o_valid / i_stall carry one result per event: channel,
// event code, stored latest and previous sample, and the next channel.
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_idx; the
// user must write only while the block is idle, which it does not enforce.
// A ready event passes from acceptance to result through a capture step
// that updates the stores, 24 bit-serial steps in which the divider and the
// four comparators consume one sample bit each, and a load of the result.
// A not-ready event skips the bit-serial steps. One event is worked at a time;
// the next one is accepted while the finished result still sits in the output
// register. When the receiver stalls, the result holds and the block stops
// after finishing the following event until the output register frees.
// Reset clears the sample stores, the scan pointer, the output valid and
// sets all limit registers to their defaults.
module adc_scan_limit_monitor #(
    parameter int NUM_CHANNELS     = acm_pkg::DEF_NUM_CHANNELS,
    parameter int SAMPLE_BITS      = acm_pkg::DEF_SAMPLE_BITS,
    parameter int FALL_CHANNEL     = acm_pkg::DEF_FALL_CHANNEL,
    parameter int PRESSURE_CHANNEL = acm_pkg::DEF_PRESSURE_CHANNEL
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [acm_pkg::IDX_W-1:0]   i_cfg_idx,
    input  logic [acm_pkg::DATA_W-1:0]  i_cfg_data,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic                        i_not_ready,
    input  logic                        i_overload,
    input  logic [acm_pkg::DATA_W-1:0]  i_sample,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [acm_pkg::CH_W-1:0]    o_channel,
    output logic [acm_pkg::CODE_W-1:0]  o_event_code,
    output logic [acm_pkg::DATA_W-1:0]  o_latest_value,
    output logic [acm_pkg::DATA_W-1:0]  o_previous_value,
    output logic [acm_pkg::CH_W-1:0]    o_next_channel
);
    import acm_pkg::*;

    localparam int PTR_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam logic [DATA_W-1:0] SMASK = (SAMPLE_BITS >= DATA_W) ? {DATA_W{1'b1}} :
        DATA_W'((64'd1 << SAMPLE_BITS) - 64'd1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(NUM_CHANNELS - 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state r_state, n_state;

    logic [DATA_W-1:0] r_min_lim [3];
    logic [DATA_W-1:0] r_max_lim [3];
    logic [DIV_W-1:0]  r_divisor;
    logic [DATA_W-1:0] r_setpoint;

    logic [DATA_W-1:0] r_latest   [NUM_CHANNELS];
    logic [DATA_W-1:0] r_previous [NUM_CHANNELS];
    logic [PTR_W-1:0]  r_ptr;

    logic [CH_W-1:0]   r_ch;
    logic [CH_W-1:0]   r_nxt;
    logic              r_nr;
    logic              r_ovl;
    logic [DATA_W-1:0] r_lat;
    logic [DATA_W-1:0] r_prv;
    logic [CNT_W-1:0]  r_cnt;

    logic [DATA_W-1:0] r_cur_sh;
    logic [DATA_W-1:0] r_max_sh;
    logic [DATA_W-1:0] r_min_sh;
    logic [DATA_W-1:0] r_sp_sh;

    logic              r_o_valid;
    logic [CH_W-1:0]   r_o_channel;
    t_event            r_o_code;
    logic [DATA_W-1:0] r_o_latest;
    logic [DATA_W-1:0] r_o_previous;
    logic [CH_W-1:0]   r_o_next;

    logic              w_accept;
    logic              w_start;
    logic              w_step;
    logic              w_load;
    logic [DATA_W-1:0] w_cur;
    logic [CH_W-1:0]   w_ch;
    logic [PTR_W-1:0]  w_ptr_nxt;
    logic              w_qbit;
    t_cmp              w_cmp_max;
    t_cmp              w_cmp_min;
    t_cmp              w_cmp_fall;
    t_cmp              w_cmp_sp;
    t_event            w_code;

    assign w_accept  = i_valid && (r_state == S_IDLE);
    assign w_start   = w_accept && !i_not_ready;
    assign w_step    = (r_state == S_RUN);
    assign w_load    = (r_state == S_DONE) && (!r_o_valid || !i_stall);
    assign w_cur     = i_sample & SMASK;
    assign w_ch      = CH_W'(r_ptr);
    assign w_ptr_nxt = (r_ptr == PTR_LAST) ? '0 : r_ptr + 1'b1;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = i_not_ready ? S_DONE : S_RUN;
                end
            end
            S_RUN: begin
                if (r_cnt == CNT_W'(DATA_W - 1)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        if (r_nr) begin
            w_code = EV_NOT_READY;
        end else if (r_ovl) begin
            w_code = EV_OVERLOAD;
        end else if (!w_cmp_max.lt) begin
            w_code = EV_MAX;
        end else if (!w_cmp_min.gt) begin
            w_code = EV_MIN;
        end else if ((r_ch == CH_W'(FALL_CHANNEL)) && w_cmp_fall.lt) begin
            w_code = EV_FALL;
        end else if ((r_ch == CH_W'(PRESSURE_CHANNEL)) && w_cmp_sp.gt) begin
            w_code = EV_PRESSURE;
        end else begin
            w_code = EV_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 3; k++) begin
                r_min_lim[k] <= LIMIT_MIN_RST;
                r_max_lim[k] <= LIMIT_MAX_RST;
            end
            r_divisor  <= DIVISOR_RST;
            r_setpoint <= LIMIT_MAX_RST;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_MIN_CH0:  r_min_lim[0] <= i_cfg_data;
                REG_MAX_CH0:  r_max_lim[0] <= i_cfg_data;
                REG_MIN_CH1:  r_min_lim[1] <= i_cfg_data;
                REG_MAX_CH1:  r_max_lim[1] <= i_cfg_data;
                REG_MIN_CH2:  r_min_lim[2] <= i_cfg_data;
                REG_MAX_CH2:  r_max_lim[2] <= i_cfg_data;
                REG_DIVISOR:  r_divisor    <= i_cfg_data[DIV_W-1:0];
                REG_SETPOINT: r_setpoint   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_ptr     <= '0;
            r_o_valid <= 1'b0;
            r_cnt     <= '0;
            for (int k = 0; k < NUM_CHANNELS; k++) begin
                r_latest[k]   <= '0;
                r_previous[k] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (w_start) begin
                r_previous[r_ptr] <= r_latest[r_ptr];
                r_latest[r_ptr]   <= w_cur;
                r_ptr             <= w_ptr_nxt;
                r_cnt             <= '0;
            end else if (w_step) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (w_load) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_ch  <= w_ch;
            r_nr  <= i_not_ready;
            r_ovl <= i_overload;
            if (i_not_ready) begin
                r_nxt <= w_ch;
                r_lat <= r_latest[r_ptr];
                r_prv <= r_previous[r_ptr];
            end else begin
                r_nxt <= CH_W'(w_ptr_nxt);
                r_lat <= w_cur;
                r_prv <= r_latest[r_ptr];
            end
        end
        if (w_start) begin
            r_cur_sh <= w_cur;
            r_max_sh <= r_max_lim[w_ch];
            r_min_sh <= r_min_lim[w_ch];
            r_sp_sh  <= r_setpoint;
        end else if (w_step) begin
            r_cur_sh <= {r_cur_sh[DATA_W-2:0], 1'b0};
            r_max_sh <= {r_max_sh[DATA_W-2:0], 1'b0};
            r_min_sh <= {r_min_sh[DATA_W-2:0], 1'b0};
            r_sp_sh  <= {r_sp_sh[DATA_W-2:0], 1'b0};
        end
        if (w_load) begin
            r_o_channel  <= r_ch;
            r_o_code     <= w_code;
            r_o_latest   <= r_lat;
            r_o_previous <= r_prv;
            r_o_next     <= r_nxt;
        end
    end

    acm_div_serial u_div (
        .i_clk      (i_clk),
        .i_start    (w_start),
        .i_step     (w_step),
        .i_dividend (r_latest[r_ptr]),
        .i_divisor  (r_divisor),
        .o_qbit     (w_qbit)
    );

    acm_cmp_serial u_cmp_max (
        .i_clk   (i_clk),
        .i_start (w_start),
        .i_step  (w_step),
        .i_a     (r_cur_sh[DATA_W-1]),
        .i_b     (r_max_sh[DATA_W-1]),
        .o_cmp   (w_cmp_max)
    );

    acm_cmp_serial u_cmp_min (
        .i_clk   (i_clk),
        .i_start (w_start),
        .i_step  (w_step),
        .i_a     (r_cur_sh[DATA_W-1]),
        .i_b     (r_min_sh[DATA_W-1]),
        .o_cmp   (w_cmp_min)
    );

    acm_cmp_serial u_cmp_fall (
        .i_clk   (i_clk),
        .i_start (w_start),
        .i_step  (w_step),
        .i_a     (r_cur_sh[DATA_W-1]),
        .i_b     (w_qbit),
        .o_cmp   (w_cmp_fall)
    );

    acm_cmp_serial u_cmp_sp (
        .i_clk   (i_clk),
        .i_start (w_start),
        .i_step  (w_step),
        .i_a     (r_cur_sh[DATA_W-1]),
        .i_b     (r_sp_sh[DATA_W-1]),
        .o_cmp   (w_cmp_sp)
    );

    assign o_stall          = (r_state != S_IDLE);
    assign o_valid          = r_o_valid;
    assign o_channel        = r_o_channel;
    assign o_event_code     = r_o_code;
    assign o_latest_value   = r_o_latest;
    assign o_previous_value = r_o_previous;
    assign o_next_channel   = r_o_next;

endmodule

/* rtl/acm_checker.sv */
// Port-level checker for the ADC scan limit monitor, with its bind.
module acm_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_cfg_we,
    input logic [acm_pkg::IDX_W-1:0]   i_cfg_idx,
    input logic [acm_pkg::DATA_W-1:0]  i_cfg_data,
    input logic                        i_valid,
    input logic                        o_stall,
    input logic                        i_not_ready,
    input logic                        i_overload,
    input logic [acm_pkg::DATA_W-1:0]  i_sample,
    input logic                        o_valid,
    input logic                        i_stall,
    input logic [acm_pkg::CH_W-1:0]    o_channel,
    input logic [acm_pkg::CODE_W-1:0]  o_event_code,
    input logic [acm_pkg::DATA_W-1:0]  o_latest_value,
    input logic [acm_pkg::DATA_W-1:0]  o_previous_value,
    input logic [acm_pkg::CH_W-1:0]    o_next_channel
);
    import acm_pkg::*;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("input accepted while block still busy");

    a_not_ready_holds_ptr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_event_code == EV_NOT_READY)) |-> (o_next_channel == o_channel))
        else $error("not-ready transaction moved the scan pointer");

    a_ready_advances_ptr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_event_code != EV_NOT_READY)) |-> (o_next_channel != o_channel))
        else $error("ready transaction did not advance the scan pointer");

    a_ready_stores_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_event_code == EV_MAX || o_event_code == EV_MIN ||
         o_event_code == EV_FALL || o_event_code == EV_PRESSURE))
        |-> (o_channel != o_next_channel))
        else $error("limit event reported without a ready sample");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_latest_value)))
        else $error("stalled result changed");

endmodule

bind adc_scan_limit_monitor acm_checker u_acm_checker (.*);

/* test/adc_scan_limit_monitor_tb.sv */
// Self-checking testbench for the ADC scan limit monitor.
`timescale 1ns / 100ps

module adc_scan_limit_monitor_tb;
    import acm_pkg::*;

    localparam int                NUM_CH      = DEF_NUM_CHANNELS;
    localparam int                FALL_CH     = DEF_FALL_CHANNEL;
    localparam int                PRESS_CH    = DEF_PRESSURE_CHANNEL;
    localparam logic [DATA_W-1:0] FULL_SCALE  = '1;
    localparam int                DRAIN_WAIT  = 32;
    localparam int                STUCK_LIMIT = 2000;

    typedef struct packed {
        logic [CH_W-1:0]   channel;
        t_event            code;
        logic [DATA_W-1:0] latest;
        logic [DATA_W-1:0] previous;
        logic [CH_W-1:0]   next_ch;
    } t_scan_result;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_cfg_we    = 1'b0;
    logic [IDX_W-1:0]  i_cfg_idx   = REG_MIN_CH0;
    logic [DATA_W-1:0] i_cfg_data  = '0;
    logic              i_valid     = 1'b0;
    logic              o_stall;
    logic              i_not_ready = 1'b0;
    logic              i_overload  = 1'b0;
    logic [DATA_W-1:0] i_sample    = '0;
    logic              o_valid;
    logic              i_stall     = 1'b0;
    logic [CH_W-1:0]   o_channel;
    logic [CODE_W-1:0] o_event_code;
    logic [DATA_W-1:0] o_latest_value;
    logic [DATA_W-1:0] o_previous_value;
    logic [CH_W-1:0]   o_next_channel;

    // scan monitor state as the block should hold it
    logic [DATA_W-1:0] min_lim [NUM_CH];
    logic [DATA_W-1:0] max_lim [NUM_CH];
    logic [DATA_W-1:0] last_mem [NUM_CH];
    logic [DATA_W-1:0] prev_mem [NUM_CH];
    logic [DIV_W-1:0]  fall_div;
    logic [DATA_W-1:0] setpoint;
    logic [CH_W-1:0]   scan_ptr;

    t_scan_result pending_results[$];

    bit quiet;
    int hold_len;
    int hold_left;
    int fail_count;
    int sent_count;
    int checked_count;
    int cfg_writes;
    int stuck_cycles;
    int code_hits [7];

    adc_scan_limit_monitor i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_not_ready      (i_not_ready),
        .i_overload       (i_overload),
        .i_sample         (i_sample),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_channel        (o_channel),
        .o_event_code     (o_event_code),
        .o_latest_value   (o_latest_value),
        .o_previous_value (o_previous_value),
        .o_next_channel   (o_next_channel)
    );

    always #5 i_clk = ~i_clk;

    task automatic reset_model();
        for (int k = 0; k < NUM_CH; k++) begin
            min_lim[k]  = LIMIT_MIN_RST;
            max_lim[k]  = LIMIT_MAX_RST;
            last_mem[k] = '0;
            prev_mem[k] = '0;
        end
        fall_div = DIVISOR_RST;
        setpoint = LIMIT_MAX_RST;
        scan_ptr = '0;
    endtask

    function automatic t_scan_result classify_event(logic nr, logic ovl,
                                                    logic [DATA_W-1:0] smp);
        t_scan_result      r;
        logic [DATA_W-1:0] dv;
        int                ch;
        ch        = scan_ptr;
        r.channel = scan_ptr;
        r.next_ch = scan_ptr;
        if (nr) begin
            r.code = EV_NOT_READY;
        end else begin
            dv = (fall_div == 0) ? DATA_W'(1) : DATA_W'(fall_div);
            prev_mem[ch] = last_mem[ch];
            last_mem[ch] = smp;
            if (ovl)
                r.code = EV_OVERLOAD;
            else if (smp >= max_lim[ch])
                r.code = EV_MAX;
            else if (smp <= min_lim[ch])
                r.code = EV_MIN;
            else if (ch == FALL_CH && smp < prev_mem[ch] / dv)
                r.code = EV_FALL;
            else if (ch == PRESS_CH && smp > setpoint)
                r.code = EV_PRESSURE;
            else
                r.code = EV_NONE;
            scan_ptr  = (ch == NUM_CH - 1) ? '0 : CH_W'(ch + 1);
            r.next_ch = scan_ptr;
        end
        r.latest   = last_mem[ch];
        r.previous = prev_mem[ch];
        return r;
    endfunction

    // bias samples toward the decision points of the channel about to convert
    function automatic logic [DATA_W-1:0] pick_sample();
        longint v;
        int     ch;
        int     dv;
        ch = scan_ptr;
        dv = (fall_div == 0) ? 1 : int'(fall_div);
        case ($urandom_range(7))
            0: v = 0;
            1: v = FULL_SCALE;
            2: v = longint'(min_lim[ch]) + int'($urandom_range(2)) - 1;
            3: v = longint'(max_lim[ch]) + int'($urandom_range(2)) - 1;
            4: v = longint'(setpoint) + int'($urandom_range(2)) - 1;
            5: v = longint'(last_mem[ch]) / dv + int'($urandom_range(2)) - 1;
            default: v = $urandom & FULL_SCALE;
        endcase
        if (v < 0)
            v = 0;
        if (v > FULL_SCALE)
            v = FULL_SCALE;
        return DATA_W'(v);
    endfunction

    task automatic write_reg(input t_reg_idx idx, input logic [DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        cfg_writes++;
        case (idx)
            REG_MIN_CH0:  min_lim[0] = data;
            REG_MAX_CH0:  max_lim[0] = data;
            REG_MIN_CH1:  min_lim[1] = data;
            REG_MAX_CH1:  max_lim[1] = data;
            REG_MIN_CH2:  min_lim[2] = data;
            REG_MAX_CH2:  max_lim[2] = data;
            REG_DIVISOR:  fall_div   = data[DIV_W-1:0];
            REG_SETPOINT: setpoint   = data;
            default: ;
        endcase
    endtask

    task automatic apply_limits(input logic [DATA_W-1:0] lo0, hi0, lo1, hi1, lo2, hi2,
                                input logic [DATA_W-1:0] div, sp);
        write_reg(REG_MIN_CH0, lo0);
        write_reg(REG_MAX_CH0, hi0);
        write_reg(REG_MIN_CH1, lo1);
        write_reg(REG_MAX_CH1, hi1);
        write_reg(REG_MIN_CH2, lo2);
        write_reg(REG_MAX_CH2, hi2);
        write_reg(REG_DIVISOR, div);
        write_reg(REG_SETPOINT, sp);
    endtask

    task automatic random_limits();
        logic [DATA_W-1:0] div;
        logic [DATA_W-1:0] lo [3];
        logic [DATA_W-1:0] hi [3];
        logic [DATA_W-1:0] sp;
        div = ($urandom_range(3) == 0) ? DATA_W'($urandom) :
              {(DATA_W-DIV_W)'($urandom_range(16'hFFFF)), DIV_W'($urandom_range(1, 8))};
        for (int k = 0; k < 3; k++) begin
            lo[k] = DATA_W'($urandom_range(24'h3FFFFF));
            hi[k] = DATA_W'($urandom_range(24'hC00000, FULL_SCALE));
        end
        sp = DATA_W'($urandom_range(24'h400000, 24'hC00000));
        apply_limits(lo[0], hi[0], lo[1], hi[1], lo[2], hi[2], div, sp);
    endtask

    // hold the payload until the transaction is taken, then maybe idle
    task automatic send_event(input logic nr, input logic ovl, input logic [DATA_W-1:0] smp);
        i_valid     <= 1'b1;
        i_not_ready <= nr;
        i_overload  <= ovl;
        i_sample    <= smp;
        do @(posedge i_clk); while (o_stall);
        pending_results.push_back(classify_event(nr, ovl, smp));
        sent_count++;
        if (!quiet && $urandom_range(99) < 10) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 40)) @(posedge i_clk);
        end
    endtask

    task automatic random_event();
        send_event($urandom_range(99) < 12, $urandom_range(99) < 10, pick_sample());
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic test_directed_events();
        send_event(1'b1, 1'b0, 24'h000000);
        send_event(1'b1, 1'b1, 24'hFFFFFF);
        send_event(1'b0, 1'b0, 24'h000000);
        send_event(1'b0, 1'b0, 24'hFFFFFF);
        send_event(1'b0, 1'b1, 24'h123456);
        send_event(1'b0, 1'b0, 24'h800000);
        send_event(1'b0, 1'b0, 24'h400000);
        send_event(1'b0, 1'b0, 24'h000001);
        send_event(1'b0, 1'b0, 24'h3FFFFF);
        send_event(1'b0, 1'b0, 24'h400001);
        send_event(1'b0, 1'b1, 24'h000000);
        send_event(1'b0, 1'b0, 24'h3FFFFF);
        wait_drained();
        // zero divisor behaves as one; upper data bits must be dropped
        apply_limits(24'h10, 24'hFFFFF0, 24'h10, 24'hFFFFF0, 24'h10, 24'hFFFFF0,
                     24'hABCD00, 24'h500000);
        send_event(1'b0, 1'b0, 24'h500001);
        send_event(1'b0, 1'b0, 24'hFFFFF0);
        send_event(1'b0, 1'b0, 24'h3FFFFE);
        send_event(1'b0, 1'b0, 24'h500000);
        send_event(1'b0, 1'b0, 24'h000010);
        send_event(1'b0, 1'b0, 24'h3FFFFE);
        send_event(1'b1, 1'b0, 24'h5A5A5A);
        send_event(1'b0, 1'b0, 24'hFFFFFF);
        send_event(1'b0, 1'b0, 24'h000011);
        wait_drained();
        write_reg(REG_DIVISOR, 24'h0000FF);
        send_event(1'b0, 1'b0, 24'h000011);
        send_event(1'b0, 1'b0, 24'h00000F);
        wait_drained();
    endtask

    task automatic test_limit_extremes();
        apply_limits(FULL_SCALE, 0, FULL_SCALE, 0, FULL_SCALE, 0, 24'h000001, 0);
        repeat (100) random_event();
        wait_drained();
        apply_limits(0, FULL_SCALE, 0, FULL_SCALE, 0, FULL_SCALE, 24'h000001, 0);
        repeat (100) random_event();
        wait_drained();
        apply_limits(1, 24'hFFFFFE, 1, 24'hFFFFFE, 1, 24'hFFFFFE, FULL_SCALE, 24'hFFFFFE);
        repeat (100) random_event();
        wait_drained();
        apply_limits(24'h000100, 24'hFFFF00, 24'h000100, 24'hFFFF00, 24'h000100, 24'hFFFF00,
                     24'h123400, 24'h800000);
        repeat (100) random_event();
        wait_drained();
    endtask

    task automatic test_random_scan();
        repeat (6) begin
            random_limits();
            repeat (150) random_event();
            wait_drained();
        end
    endtask

    task automatic test_back_to_back();
        quiet = 1'b1;
        random_limits();
        repeat (200) random_event();
        wait_drained();
        quiet = 1'b0;
    endtask

    // block the output long enough that the input side backs up
    task automatic test_output_hold();
        random_limits();
        hold_len = 400;
        repeat (80) random_event();
        wait_drained();
    endtask

    always @(posedge i_clk) begin
        if (hold_len != 0) begin
            hold_left = hold_len;
            hold_len  = 0;
        end
        if (hold_left > 0) begin
            i_stall <= 1'b1;
            hold_left--;
        end else begin
            i_stall <= !quiet && ($urandom_range(99) < 10);
        end
    end

    always @(posedge i_clk) begin : result_check
        t_scan_result got;
        t_scan_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            checked_count++;
            got.channel  = o_channel;
            got.code     = t_event'(o_event_code);
            got.latest   = o_latest_value;
            got.previous = o_previous_value;
            got.next_ch  = o_next_channel;
            if (pending_results.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected result: ch %0d code %0d latest %h prev %h next %0d",
                             got.channel, got.code, got.latest, got.previous, got.next_ch);
            end else begin
                want = pending_results.pop_front();
                code_hits[want.code]++;
                if (got.channel !== want.channel || got.code !== want.code ||
                    got.latest !== want.latest || got.previous !== want.previous ||
                    got.next_ch !== want.next_ch) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $write("mismatch (exp/got): ch %0d/%0d code %0d/%0d ",
                               want.channel, got.channel, want.code, got.code);
                        $display("latest %h/%h prev %h/%h next %0d/%0d",
                                 want.latest, got.latest, want.previous, got.previous,
                                 want.next_ch, got.next_ch);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall))
            stuck_cycles = 0;
        else
            stuck_cycles++;
        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", STUCK_LIMIT);
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        reset_model();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_events();
        test_limit_extremes();
        test_random_scan();
        test_back_to_back();
        test_output_hold();
        fail_count += pending_results.size();
        $display("Sent %0d converter events, checked %0d results, %0d register writes.",
                 sent_count, checked_count, cfg_writes);
        $write("Codes seen: none %0d, not ready %0d, overload %0d, max %0d, ",
               code_hits[EV_NONE], code_hits[EV_NOT_READY], code_hits[EV_OVERLOAD],
               code_hits[EV_MAX]);
        $display("min %0d, fall %0d, pressure %0d",
                 code_hits[EV_MIN], code_hits[EV_FALL], code_hits[EV_PRESSURE]);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

/* filelist.f */
rtl/acm_pkg.sv
rtl/acm_div_serial.sv
rtl/acm_cmp_serial.sv
rtl/adc_scan_limit_monitor.sv
rtl/acm_checker.sv
test/adc_scan_limit_monitor_tb.sv
